// ===== src/wwg_pkg.sv =====
// Package for the wireworld grid engine: grid sizes, cell codes, action codes,
// configuration register indexes and the sequencer state type.
// No dependencies.
package wwg_pkg;

  localparam int unsigned MAX_COLS = 128;
  localparam int unsigned MAX_ROWS = 128;
  localparam int unsigned COL_W    = $clog2(MAX_COLS);
  localparam int unsigned ROW_AW   = $clog2(MAX_ROWS);
  localparam int unsigned SIZE_W   = 8;
  localparam int unsigned CNT_W    = ROW_AW + 1;
  localparam int unsigned ROW_BITS = 2 * MAX_COLS;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_WIRE  = 2'd1;
  localparam logic [1:0] CELL_HEAD  = 2'd2;
  localparam logic [1:0] CELL_TAIL  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ACT_WRITE    = 3'd0,
    ACT_READ     = 3'd1,
    ACT_STEP     = 3'd2,
    ACT_CLEAR    = 3'd3,
    ACT_POWEROFF = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_MOD,
    ST_SRD,
    ST_SCMP,
    ST_CLR,
    ST_PRD,
    ST_PWR,
    ST_DONE
  } state_e;

endpackage

// ===== src/wwg_if.sv =====
// Valid/ready channel interfaces for the wireworld grid engine.
// Depends on wwg_pkg for field widths.
interface wwg_req_if;
  import wwg_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       action;
  logic [COL_W-1:0] col;
  logic [ROW_AW-1:0] row;
  logic [1:0]       cell_in;
  modport source (output valid, action, col, row, cell_in, input ready);
  modport sink   (input valid, action, col, row, cell_in, output ready);
endinterface

interface wwg_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] cell_out;
  logic       in_range;
  modport source (output valid, cell_out, in_range, input ready);
  modport sink   (input valid, cell_out, in_range, output ready);
endinterface

// ===== src/wireworld_grid_step.sv =====
// Wireworld grid engine: row-wide grid memory, row sequencer and output register.
// Depends on wwg_pkg and the channel interfaces in wwg_if.sv.
// Write/read fetch the row and a write stores it patched; step and power-off sweep
// the used rows, clear sweeps all rows; an unknown action or out-of-range address
// goes straight to the result. One transaction at a time; a held result stalls the
// sequencer in its last cycle. Reset: sizes go to 100 x 100, then a clearing pass.
module wireworld_grid_step (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wwg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wwg_pkg::SIZE_W-1:0]   cfg_data_i,
  wwg_req_if.sink                      req_i,
  wwg_rsp_if.source                    rsp_o
);
  import wwg_pkg::*;

  state_e state_q, state_d;

  logic [SIZE_W-1:0]   width_q, height_q;
  logic [SIZE_W-1:0]   used_w, used_h;
  logic [CNT_W-1:0]    cnt_q;
  logic [COL_W-1:0]    col_q;
  logic [ROW_AW-1:0]   row_q;
  logic [1:0]          cell_q;
  logic                is_write_q;
  logic [1:0]          res_cell_q;
  logic                res_range_q;
  logic                out_valid_q;
  logic [1:0]          out_cell_q;
  logic                out_range_q;
  logic [ROW_BITS-1:0] prev_q, cur_q;

  logic [ROW_BITS-1:0] mem [MAX_ROWS];
  logic [ROW_BITS-1:0] rd_data_q;
  logic [ROW_AW-1:0]   rd_addr, wr_addr;
  logic [ROW_BITS-1:0] wr_data;
  logic                mem_we;

  logic                accept, in_grid, out_free;
  logic [ROW_BITS-1:0] nxt_row, step_row, po_row, mod_row;
  logic [MAX_COLS+1:0] hp, hc, hn;
  logic [MAX_COLS-1:0] col_ok;
  logic [3:0]          nb;

  // Clamp size registers to the legal range
  always_comb begin
    used_w = (width_q == '0) ? SIZE_W'(1) :
             (width_q > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : width_q;
    used_h = (height_q == '0) ? SIZE_W'(1) :
             (height_q > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : height_q;
  end

  assign accept   = req_i.valid && req_i.ready;
  assign in_grid  = ({1'b0, req_i.col} < used_w) && ({1'b0, req_i.row} < used_h);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: if (cnt_q == CNT_W'(MAX_ROWS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.action)
            ACT_WRITE, ACT_READ: state_d = in_grid ? ST_RD : ST_DONE;
            ACT_STEP:            state_d = ST_SRD;
            ACT_CLEAR:           state_d = ST_CLR;
            ACT_POWEROFF:        state_d = ST_PRD;
            default:             state_d = ST_DONE;
          endcase
        end
      end
      ST_RD:   state_d = ST_MOD;
      ST_MOD:  state_d = ST_DONE;
      ST_SRD:  state_d = ST_SCMP;
      ST_SCMP: state_d = (cnt_q == CNT_W'(used_h)) ? ST_DONE : ST_SRD;
      ST_CLR:  if (cnt_q == CNT_W'(MAX_ROWS - 1)) state_d = ST_DONE;
      ST_PRD:  state_d = ST_PWR;
      ST_PWR:  state_d = (cnt_q == CNT_W'(used_h - SIZE_W'(1))) ? ST_DONE : ST_PRD;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Head bits of the three rows around the current one, padded at both ends
  always_comb begin
    nxt_row = (cnt_q < CNT_W'(used_h)) ? rd_data_q : '0;
    hp = '0;
    hc = '0;
    hn = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      col_ok[c] = (CNT_W'(c) < CNT_W'(used_w));
      hp[c+1] = col_ok[c] && (prev_q[2*c +: 2] == CELL_HEAD);
      hc[c+1] = col_ok[c] && (cur_q[2*c +: 2] == CELL_HEAD);
      hn[c+1] = col_ok[c] && (nxt_row[2*c +: 2] == CELL_HEAD);
    end
  end

  // Next generation of one row, lanes side by side
  always_comb begin
    nb = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      nb = {3'b0, hp[c]} + {3'b0, hp[c+1]} + {3'b0, hp[c+2]} + {3'b0, hc[c]}
         + {3'b0, hc[c+2]} + {3'b0, hn[c]} + {3'b0, hn[c+1]} + {3'b0, hn[c+2]};
      step_row[2*c +: 2] = cur_q[2*c +: 2];
      if (col_ok[c]) begin
        case (cur_q[2*c +: 2])
          CELL_HEAD: step_row[2*c +: 2] = CELL_TAIL;
          CELL_TAIL: step_row[2*c +: 2] = CELL_WIRE;
          CELL_WIRE: step_row[2*c +: 2] = (nb == 4'd1 || nb == 4'd2) ? CELL_HEAD : CELL_WIRE;
          default:   step_row[2*c +: 2] = CELL_EMPTY;
        endcase
      end
      po_row[2*c +: 2] = (col_ok[c] && rd_data_q[2*c+1]) ? CELL_WIRE : rd_data_q[2*c +: 2];
    end
  end

  // Patch one cell into the fetched row
  always_comb begin
    mod_row = rd_data_q;
    mod_row[{col_q, 1'b0} +: 2] = cell_q;
  end

  // Memory port control
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = cnt_q[ROW_AW-1:0];
    wr_data = '0;
    rd_addr = cnt_q[ROW_AW-1:0];
    unique case (state_q)
      ST_INIT, ST_CLR: mem_we = 1'b1;
      ST_RD:  rd_addr = row_q;
      ST_MOD: begin
        mem_we  = is_write_q;
        wr_addr = row_q;
        wr_data = mod_row;
      end
      ST_SCMP: begin
        mem_we  = (cnt_q != '0);
        wr_addr = ROW_AW'(cnt_q - CNT_W'(1));
        wr_data = step_row;
      end
      ST_PWR: begin
        mem_we  = 1'b1;
        wr_data = po_row;
      end
      default: ;
    endcase
  end

  // Row memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      width_q     <= SIZE_W'(100);
      height_q    <= SIZE_W'(100);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == CFG_GRID_WIDTH)  width_q  <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_GRID_HEIGHT) height_q <= cfg_data_i;
      // advance the row counter
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == ST_INIT || state_q == ST_CLR || state_q == ST_SCMP
                   || state_q == ST_PWR) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      // hold the result until taken
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Transaction payload and row window
  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q       <= req_i.col;
      row_q       <= req_i.row;
      cell_q      <= req_i.cell_in;
      is_write_q  <= (req_i.action == ACT_WRITE);
      res_cell_q  <= CELL_EMPTY;
      res_range_q <= in_grid && (req_i.action == ACT_WRITE || req_i.action == ACT_READ);
      prev_q      <= '0;
      cur_q       <= '0;
    end
    if (state_q == ST_MOD && !is_write_q) begin
      res_cell_q <= rd_data_q[{col_q, 1'b0} +: 2];
    end
    if (state_q == ST_SCMP) begin
      prev_q <= cur_q;
      cur_q  <= rd_data_q;
    end
    if (state_q == ST_DONE && out_free) begin
      out_cell_q  <= res_cell_q;
      out_range_q <= res_range_q;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.cell_out = out_cell_q;
  assign rsp_o.in_range = out_range_q;

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q != ST_IDLE && state_q != ST_DONE)
    else $error("memory written outside a sequence");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCMP |-> cnt_q <= CNT_W'(used_h))
    else $error("step counter past last row");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_free |=> out_valid_q && state_q == ST_IDLE)
    else $error("result not loaded");
  a_cell_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_cell_q != CELL_EMPTY |-> out_range_q)
    else $error("cell returned for out-of-range address");

endmodule
